/* rtl/core/pnms_pkg.sv */
// Package for the packed nucleotide mismatch scanner: constants, register codes,
// channel payload types and the 64-bit population count.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pnms_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_BLOCKS    = 4;
    localparam int DEF_POSITION_BITS = 30;

    // Fixed widths of words, nibbles and fields.
    localparam int WORD_W        = 64;
    localparam int NIBBLES       = 16;
    localparam int NIBBLE_W      = 4;
    localparam int LOC_W         = 34;
    localparam int COUNT_W       = 7;
    localparam int TAG_W         = 16;
    localparam int BLOCK_COUNT_W = 3;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int PATTERN_REGS  = 4;

    // Register values after reset.
    localparam logic [BLOCK_COUNT_W-1:0] RST_BLOCK_COUNT    = 3'd1;
    localparam logic [COUNT_W-1:0]       RST_PATTERN_LENGTH = 7'd16;
    localparam logic [COUNT_W-1:0]       RST_MAX_MISMATCH   = 7'd0;
    localparam logic [TAG_W-1:0]         RST_PATTERN_TAG    = 16'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0      = 3'd0,
        REG_PATTERN_1      = 3'd1,
        REG_PATTERN_2      = 3'd2,
        REG_PATTERN_3      = 3'd3,
        REG_BLOCK_COUNT    = 3'd4,
        REG_PATTERN_LENGTH = 3'd5,
        REG_MAX_MISMATCH   = 3'd6,
        REG_PATTERN_TAG    = 3'd7
    } cfg_reg_t;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Payload of the genome word channel.
    typedef struct packed {
        logic [WORD_W-1:0] genome_word;
        logic              restart;
    } pnms_in_t;

    // Payload of the result channel.
    typedef struct packed {
        logic [LOC_W-1:0]   location;
        logic [COUNT_W-1:0] mismatch_count;
        logic [TAG_W-1:0]   match_tag;
        logic               last_of_run;
    } pnms_out_t;

    // Population count of a 64-bit word as a balanced adder tree.
    function automatic count_t popcount64(input word_t v);
        logic [1:0] lvl1 [32];
        logic [2:0] lvl2 [16];
        logic [3:0] lvl3 [8];
        logic [4:0] lvl4 [4];
        logic [5:0] lvl5 [2];
        for (int i = 0; i < 32; i++) begin
            lvl1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
        end
        return {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pnms_if.sv */
// Valid/ready channel interfaces of the packed nucleotide mismatch scanner.
// Depends on pnms_pkg for the payload types.
`default_nettype none

// Genome word channel.
interface pnms_in_if import pnms_pkg::*; ();
    logic     valid;
    logic     ready;
    pnms_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface pnms_out_if import pnms_pkg::*; ();
    logic      valid;
    logic      ready;
    pnms_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/packed_nucleotide_mismatch_scan_top.sv */
// Packed nucleotide mismatch scanner: sliding genome window, pattern AND and
// popcount over 16 nibble offsets, and a result serialiser.
// Depends on pnms_pkg and the channel interfaces in pnms_if.
//
// Usage: the genome_in channel takes one 64-bit word of sixteen nucleotide codes per
// transaction, first nucleotide in the top nibble; restart empties the window first.
// Patterns are loaded through the cfg_we/cfg_index/cfg_data write port while idle.
// Once block_count+1 words are in the window, each new word scans the 16 offsets of
// the oldest word; every offset with mismatch_count <= max_mismatch gives one
// transaction on result_out, in ascending offset order, last_of_run on the final one.
// The first result of a word is offered once the word has passed the popcount,
// compare and serialiser stages. A word is taken every cycle while each word
// yields at most one result and the receiver takes each result when offered; a word
// with several results occupies the result serialiser until its last one is taken,
// so a following word with results holds the input once it reaches the compare stage.
// When the receiver stalls, the serialiser holds its transaction; words keep moving
// while the compare stage holds no matches, and ready drops once a word with matches
// waits there for the serialiser.
// Reset clears the window fill, the position, all stage valid flags and sets the
// configuration registers to their defaults; no clearing pass is needed.
`default_nettype none

module packed_nucleotide_mismatch_scan_top import pnms_pkg::*; #(
    parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    pnms_in_if.sink                     genome_in,
    pnms_out_if.source                  result_out
);

    localparam int WIN_DEPTH = MAX_BLOCKS + 1;
    localparam int FILL_W    = $clog2(MAX_BLOCKS + 2);
    localparam int SUM_W     = $clog2(WORD_W * MAX_BLOCKS + 1);

    // Configuration registers.
    word_t                    pattern_reg [MAX_BLOCKS];
    logic [BLOCK_COUNT_W-1:0] block_count_reg;
    count_t                   pattern_length_reg;
    count_t                   max_mismatch_reg;
    logic [TAG_W-1:0]         pattern_tag_reg;

    // Window state.
    word_t                    win_reg  [WIN_DEPTH];
    word_t                    win_next [WIN_DEPTH];
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     scan_reg, scan_next;

    // Popcount stage.
    count_t                   pc_reg  [NIBBLES][MAX_BLOCKS];
    count_t                   pc_next [NIBBLES][MAX_BLOCKS];
    logic                     s2_valid_reg;
    logic [POSITION_BITS-1:0] s2_pos_reg;

    // Compare stage.
    logic [NIBBLES-1:0]       hit_reg, hit_next;
    count_t                   miss_reg  [NIBBLES];
    count_t                   miss_next [NIBBLES];
    logic [POSITION_BITS-1:0] s3_pos_reg;

    // Result serialiser.
    logic [NIBBLES-1:0]       ser_mask_reg;
    count_t                   ser_miss_reg [NIBBLES];
    logic [POSITION_BITS-1:0] ser_pos_reg;

    logic [FILL_W-1:0]        blocks_used;
    logic [FILL_W-1:0]        fill_start, drop, fill_kept;
    logic [POSITION_BITS-1:0] pos_start;
    logic                     s3_busy, ser_free, advance, accept, ser_take, ser_last;
    logic [NIBBLES-1:0]       ser_low, ser_rest;
    logic [NIBBLE_W-1:0]      sel_offset;
    count_t                   sel_miss;
    logic [POSITION_BITS+NIBBLE_W-1:0] loc_full;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BLOCKS; b++)
            begin
                pattern_reg[b] <= '0;
            end
            block_count_reg    <= RST_BLOCK_COUNT;
            pattern_length_reg <= RST_PATTERN_LENGTH;
            max_mismatch_reg   <= RST_MAX_MISMATCH;
            pattern_tag_reg    <= RST_PATTERN_TAG;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index)) inside
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                begin
                    for (int b = 0; b < MAX_BLOCKS; b++)
                    begin
                        if (b < PATTERN_REGS && cfg_index == CFG_INDEX_W'(b))
                        begin
                            pattern_reg[b] <= cfg_data;
                        end
                    end
                end
                REG_BLOCK_COUNT:    block_count_reg    <= cfg_data[BLOCK_COUNT_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[COUNT_W-1:0];
                REG_MAX_MISMATCH:   max_mismatch_reg   <= cfg_data[COUNT_W-1:0];
                REG_PATTERN_TAG:    pattern_tag_reg    <= cfg_data[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Number of pattern words in use, with out-of-range counts clamped.
    always_comb
    begin
        if (block_count_reg == '0)
        begin
            blocks_used = FILL_W'(1);
        end
        else if (32'(block_count_reg) > MAX_BLOCKS)
        begin
            blocks_used = FILL_W'(MAX_BLOCKS);
        end
        else
        begin
            blocks_used = FILL_W'(block_count_reg);
        end
    end

    // Pipeline control: all stages move together unless the compare stage holds
    // hits that the serialiser cannot take yet.
    assign ser_low   = ser_mask_reg & (~ser_mask_reg + 1'b1);
    assign ser_rest  = ser_mask_reg & ~ser_low;
    assign ser_last  = (ser_rest == '0);
    assign ser_take  = result_out.valid && result_out.ready;
    assign s3_busy   = (hit_reg != '0);
    assign ser_free  = (ser_mask_reg == '0) || (result_out.ready && ser_last);
    assign advance   = !s3_busy || ser_free;
    assign accept    = genome_in.valid && advance;
    assign genome_in.ready = advance;

    // Window update: drop the oldest words until there is room, then append.
    always_comb
    begin
        word_t shifted;
        fill_start = genome_in.data.restart ? '0 : fill_reg;
        pos_start  = genome_in.data.restart ? '0 : pos_reg;
        drop       = (fill_start > blocks_used) ? fill_start - blocks_used : '0;
        fill_kept  = fill_start - drop;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            shifted = win_reg[i];
            for (int c = 0; i + c < WIN_DEPTH; c++)
            begin
                if (drop == FILL_W'(c))
                begin
                    shifted = win_reg[i+c];
                end
            end
            if (FILL_W'(i) < fill_kept)
            begin
                win_next[i] = shifted;
            end
            else if (FILL_W'(i) == fill_kept)
            begin
                win_next[i] = genome_in.data.genome_word;
            end
            else
            begin
                win_next[i] = win_reg[i];
            end
        end
        fill_next = fill_kept + 1'b1;
        pos_next  = pos_start + POSITION_BITS'(drop);
        scan_next = (fill_kept == blocks_used);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            scan_reg <= 1'b0;
        end
        else if (advance)
        begin
            scan_reg <= accept && scan_next;
            if (accept)
            begin
                fill_reg <= fill_next;
                pos_reg  <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Popcount of each shifted window word against its pattern word.
    always_comb
    begin
        logic [2*WORD_W-1:0] pair;
        word_t               cur;
        for (int k = 0; k < NIBBLES; k++)
        begin
            for (int l = 0; l < MAX_BLOCKS; l++)
            begin
                pair = {win_reg[l], win_reg[l+1]};
                cur  = pair[2*WORD_W-1-NIBBLE_W*k -: WORD_W];
                if (FILL_W'(l) < blocks_used)
                begin
                    pc_next[k][l] = popcount64(cur & pattern_reg[l]);
                end
                else
                begin
                    pc_next[k][l] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= scan_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_pos_reg <= pos_reg;
            for (int k = 0; k < NIBBLES; k++)
            begin
                for (int l = 0; l < MAX_BLOCKS; l++)
                begin
                    pc_reg[k][l] <= pc_next[k][l];
                end
            end
        end
    end

    // Sum over the pattern words and compare with the length and threshold.
    always_comb
    begin
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] len_ext;
        len_ext = SUM_W'(pattern_length_reg);
        for (int k = 0; k < NIBBLES; k++)
        begin
            total = '0;
            for (int l = 0; l < MAX_BLOCKS; l++)
            begin
                total = total + SUM_W'(pc_reg[k][l]);
            end
            miss_next[k] = COUNT_W'(len_ext - total);
            hit_next[k]  = s2_valid_reg && (total <= len_ext)
                           && (miss_next[k] <= max_mismatch_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
        end
        else if (advance)
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_pos_reg <= s2_pos_reg;
            for (int k = 0; k < NIBBLES; k++)
            begin
                miss_reg[k] <= miss_next[k];
            end
        end
    end

    // Result serialiser: one transaction per set bit, lowest offset first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_mask_reg <= '0;
        end
        else if (advance && s3_busy)
        begin
            ser_mask_reg <= hit_reg;
        end
        else if (ser_take)
        begin
            ser_mask_reg <= ser_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s3_busy)
        begin
            ser_pos_reg <= s3_pos_reg;
            for (int k = 0; k < NIBBLES; k++)
            begin
                ser_miss_reg[k] <= miss_reg[k];
            end
        end
    end

    // Select the offset and mismatch count of the lowest pending hit.
    always_comb
    begin
        sel_offset = '0;
        sel_miss   = '0;
        for (int k = 0; k < NIBBLES; k++)
        begin
            if (ser_low[k])
            begin
                sel_offset = NIBBLE_W'(k);
                sel_miss   = ser_miss_reg[k];
            end
        end
    end

    assign loc_full = {ser_pos_reg, sel_offset};

    always_comb
    begin
        result_out.valid               = (ser_mask_reg != '0);
        result_out.data.location       = LOC_W'(loc_full);
        result_out.data.mismatch_count = sel_miss;
        result_out.data.match_tag      = pattern_tag_reg;
        result_out.data.last_of_run    = ser_last;
    end

endmodule

`default_nettype wire

/* rtl/core/pnms_checker.sv */
// Port-level checks on the result channel of the packed nucleotide mismatch scanner,
// bound to the top level. Depends on pnms_pkg for the result payload type.
`default_nettype none

module pnms_checker import pnms_pkg::*; (
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire pnms_out_t out_data
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A run that is not finished continues in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("run of results broken off before its last transaction");

    // Within a run the offsets rise and the word position stays.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=>
            out_data.location[LOC_W-1:NIBBLE_W] == $past(out_data.location[LOC_W-1:NIBBLE_W])
            && out_data.location[NIBBLE_W-1:0] > $past(out_data.location[NIBBLE_W-1:0]))
        else $error("result locations out of order within a run");

    // All results of a run carry the same tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=>
            out_data.match_tag == $past(out_data.match_tag))
        else $error("tag changed within a run");

endmodule

bind packed_nucleotide_mismatch_scan_top pnms_checker u_pnms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result_out.data)
);

`default_nettype wire
